### rtl/assert_macros.svh
// Assertion macros for the RTL of the saturation adjust block.
// No dependencies; define SYNTHESIS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check, masked while reset is asserted.
`define PSA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// Concurrent check, active during reset as well.
`define PSA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");
`else
`define PSA_ASSERT(lbl, clk, rstn, prop)
`define PSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/psa_pkg.sv
// Package for the pixel saturation adjust block: pixel types and constants.
// No dependencies.
`default_nettype none
package psa_pkg;

	localparam int PIX_W                 = 8;
	localparam int FACTOR_W              = 16;
	localparam int FACTOR_FRAC_BITS_DEF  = 8;
	localparam int CFG_INDEX_W           = 2;
	localparam int CFG_DATA_W            = FACTOR_W;

	// BT.601 luma weights, 14 fraction bits
	localparam int LUMA_SHIFT = 14;
	localparam int LUMA_SUM_W = 22;
	localparam logic [13:0] LUMA_WB = 14'd1868;
	localparam logic [13:0] LUMA_WG = 14'd9617;
	localparam logic [13:0] LUMA_WR = 14'd4899;

	localparam logic [15:0] FACTOR_ONE_DEF = 16'd256;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t blue;
		pix_t green;
		pix_t red;
	} pix3_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SATURATION_FACTOR = 2'd0,
		REG_GRAY_ONLY_MODE    = 2'd1
	} cfg_reg_t;

endpackage
`default_nettype wire

### rtl/psa_luma.sv
// Luma stages of the saturation adjust pipeline: weighted sum, then rounding.
// Depends on psa_pkg.
`default_nettype none
module psa_luma (
	input  wire logic          clk,
	input  wire logic          adv,
	input  wire psa_pkg::pix3_t pix,
	output psa_pkg::pix_t      y_s2,
	output psa_pkg::pix3_t     pix_s2
);
	import psa_pkg::*;

	logic [LUMA_SUM_W-1:0] sum_s1;
	logic [LUMA_SUM_W-1:0] sum_next;
	logic [LUMA_SUM_W-1:0] sum_rnd;
	pix3_t                 pix_s1;

	assign sum_next = LUMA_SUM_W'(LUMA_WB) * LUMA_SUM_W'(pix.blue)
	                + LUMA_SUM_W'(LUMA_WG) * LUMA_SUM_W'(pix.green)
	                + LUMA_SUM_W'(LUMA_WR) * LUMA_SUM_W'(pix.red);

	// round half up; the sum stays below 2^22 even with the offset
	assign sum_rnd = sum_s1 + (LUMA_SUM_W'(1) << (LUMA_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_next;
			pix_s1 <= pix;
			y_s2   <= sum_rnd[LUMA_SHIFT +: PIX_W];
			pix_s2 <= pix_s1;
		end
	end

endmodule
`default_nettype wire

### rtl/psa_blend.sv
// One channel of the blend: product stage, then scale, round and clamp.
// Depends on psa_pkg.
`default_nettype none
module psa_blend #(
	parameter int FRAC_BITS = psa_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        adv,
	input  wire psa_pkg::pix_t               c_s2,
	input  wire psa_pkg::pix_t               y_s2,
	input  wire logic [psa_pkg::FACTOR_W-1:0] factor,
	output psa_pkg::pix_t                    res
);
	import psa_pkg::*;

	localparam int DIFF_W = PIX_W + 1;
	localparam int PROD_W = FACTOR_W + 1 + DIFF_W;
	localparam int T_W    = PROD_W + 1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_s3;
	pix_t                     y_s3;
	logic signed [T_W-1:0]    y_sc;
	logic signed [T_W-1:0]    half;
	logic signed [T_W-1:0]    t;

	assign diff = $signed({1'b0, c_s2}) - $signed({1'b0, y_s2});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= $signed({1'b0, factor}) * diff;
			y_s3    <= y_s2;
		end
	end

	assign y_sc = T_W'(y_s3) << FRAC_BITS;
	assign half = T_W'(1) << (FRAC_BITS - 1);
	assign t    = y_sc + T_W'(prod_s3) + half;

	// clamp: negative to zero, anything past the top level to full scale
	always_comb begin
		if (t[T_W-1]) begin
			res = '0;
		end else if (|t[T_W-2:FRAC_BITS+PIX_W]) begin
			res = '1;
		end else begin
			res = t[FRAC_BITS +: PIX_W];
		end
	end

endmodule
`default_nettype wire

### rtl/psa_skid.sv
// Output register with a skid entry; decouples the pipeline from out_stall.
// Depends on psa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module psa_skid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pipe_valid,
	input  wire psa_pkg::pix3_t pipe_data,
	output logic                adv,
	output logic                out_valid,
	output psa_pkg::pix3_t      out_data,
	input  wire logic           out_stall
);
	import psa_pkg::*;

	logic  skid_valid_q;
	pix3_t skid_data_q;
	logic  held;

	assign adv  = !skid_valid_q;
	assign held = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (held) begin
			if (adv && pipe_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid    <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (held) begin
			if (adv && pipe_valid) begin
				skid_data_q <= pipe_data;
			end
		end else if (skid_valid_q) begin
			out_data <= skid_data_q;
		end else begin
			out_data <= pipe_data;
		end
	end

	`PSA_ASSERT(a_skid_needs_out, clk, arst_n, skid_valid_q |-> out_valid)
	`PSA_ASSERT(a_skid_fill_cause, clk, arst_n, $rose(skid_valid_q) |-> $past(held))
	`PSA_ASSERT(a_drain_keeps_out, clk, arst_n, (skid_valid_q && !out_stall) |=> out_valid)

endmodule
`default_nettype wire

### rtl/pixel_saturation_adjust_core.sv
// Top level of the pixel saturation adjust block: config registers,
// valid pipeline and gray bypass. Depends on psa_pkg, psa_luma, psa_blend, psa_skid.
//
//  channel   signals                                    transfer when
//  input     in_valid, in_stall, blue/green/red_in      in_valid && !in_stall
//  output    out_valid, out_stall, blue/green/red_out   out_valid && !out_stall
//  config    cfg_we, cfg_index, cfg_data                cfg_we
//
// One pixel per clock sustained while out_stall and the skid entry allow it;
// a transaction accepted at an edge passes four register stages (luma sum,
// luma round, product, output register) before out_valid rises.
// Reset clears the valid bits, the skid entry and the registers to factor
// one and color mode. A stall on the output fills the skid entry, and only a
// full skid entry raises in_stall, which freezes every pipeline stage.
`default_nettype none
module pixel_saturation_adjust_core #(
	parameter int FACTOR_FRAC_BITS = psa_pkg::FACTOR_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire psa_pkg::pix_t                  blue_in,
	input  wire psa_pkg::pix_t                  green_in,
	input  wire psa_pkg::pix_t                  red_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output psa_pkg::pix_t                       blue_out,
	output psa_pkg::pix_t                       green_out,
	output psa_pkg::pix_t                       red_out,
	input  wire logic                           cfg_we,
	input  wire logic [psa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [psa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psa_pkg::*;

	logic [FACTOR_W-1:0] factor_q;
	logic                gray_q;

	logic  adv;
	logic  v_s1, v_s2, v_s3;
	logic  g_s1, g_s2, g_s3;
	pix3_t pix_in;
	pix3_t pix_s2;
	pix3_t pix_s3;
	pix_t  y_s2;
	pix3_t blend_res;
	pix3_t pipe_data;
	pix3_t out_data;

	// configuration registers; to be written only while the block is idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_W'(1) << FACTOR_FRAC_BITS;
			gray_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SATURATION_FACTOR: factor_q <= cfg_data;
				REG_GRAY_ONLY_MODE:    gray_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a full skid entry is the only back pressure
	assign in_stall = !adv;

	// advance valid bits alongside the data; hold all of them on a freeze
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// gray flag and raw pixel ride along for the bypass
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1   <= gray_q;
			g_s2   <= g_s1;
			g_s3   <= g_s2;
			pix_s3 <= pix_s2;
		end
	end

	assign pix_in = '{blue: blue_in, green: green_in, red: red_in};

	psa_luma u_luma (
		.clk    (clk),
		.adv    (adv),
		.pix    (pix_in),
		.y_s2   (y_s2),
		.pix_s2 (pix_s2)
	);

	psa_blend #(.FRAC_BITS(FACTOR_FRAC_BITS)) u_blend_b (
		.clk    (clk),
		.adv    (adv),
		.c_s2   (pix_s2.blue),
		.y_s2   (y_s2),
		.factor (factor_q),
		.res    (blend_res.blue)
	);

	psa_blend #(.FRAC_BITS(FACTOR_FRAC_BITS)) u_blend_g (
		.clk    (clk),
		.adv    (adv),
		.c_s2   (pix_s2.green),
		.y_s2   (y_s2),
		.factor (factor_q),
		.res    (blend_res.green)
	);

	psa_blend #(.FRAC_BITS(FACTOR_FRAC_BITS)) u_blend_r (
		.clk    (clk),
		.adv    (adv),
		.c_s2   (pix_s2.red),
		.y_s2   (y_s2),
		.factor (factor_q),
		.res    (blend_res.red)
	);

	// gray-only pixels pass through untouched
	assign pipe_data = g_s3 ? pix_s3 : blend_res;

	psa_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (v_s3),
		.pipe_data  (pipe_data),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.out_stall  (out_stall)
	);

	assign blue_out  = out_data.blue;
	assign green_out = out_data.green;
	assign red_out   = out_data.red;

endmodule
`default_nettype wire

### dv/psa_sat_tb_pkg.sv
// Scoreboard for the pixel saturation adjust testbench: predicts each output
// pixel from the mirrored registers and checks the block's output in order.
// Depends on psa_pkg.
package psa_sat_tb_pkg;
	import psa_pkg::*;

	localparam int SAT_FRAC = FACTOR_FRAC_BITS_DEF;

	class saturation_checker;
		logic [FACTOR_W-1:0] factor;
		bit                  gray_mode;
		pix3_t               expected_pix[$];
		int unsigned         mismatch_cnt;

		function new();
			factor       = FACTOR_ONE_DEF;
			gray_mode    = 1'b0;
			mismatch_cnt = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_SATURATION_FACTOR: factor = data;
				REG_GRAY_ONLY_MODE:    gray_mode = data[0];
				default: ;
			endcase
		endfunction

		// s*c + (1-s)*y at scale 2^SAT_FRAC, round half up, clamp to 0..255
		function pix_t blend_channel(pix_t c, pix_t y);
			longint t;
			t = longint'(y) * (longint'(1) << SAT_FRAC)
				+ longint'(factor) * (longint'(c) - longint'(y))
				+ (longint'(1) << (SAT_FRAC - 1));
			if (t < 0)
				return '0;
			t = t >>> SAT_FRAC;
			if (t > 255)
				return 8'd255;
			return pix_t'(t);
		endfunction

		function pix3_t adjust_pixel(pix3_t p);
			longint luma_sum;
			pix_t   luma;
			pix3_t  q;
			if (gray_mode)
				return p;
			luma_sum = longint'(LUMA_WB) * longint'(p.blue)
				+ longint'(LUMA_WG) * longint'(p.green)
				+ longint'(LUMA_WR) * longint'(p.red)
				+ (longint'(1) << (LUMA_SHIFT - 1));
			luma = pix_t'(luma_sum >> LUMA_SHIFT);
			q.blue  = blend_channel(p.blue, luma);
			q.green = blend_channel(p.green, luma);
			q.red   = blend_channel(p.red, luma);
			return q;
		endfunction

		function void note_pixel(pix3_t p);
			expected_pix.insert(expected_pix.size(), adjust_pixel(p));
		endfunction

		function void check_pixel(pix3_t got);
			pix3_t want;
			if (expected_pix.size() == 0) begin
				$error("unexpected output pixel: blue %0d green %0d red %0d",
					got.blue, got.green, got.red);
				mismatch_cnt++;
				return;
			end
			want = expected_pix.pop_front();
			if (got.blue !== want.blue) begin
				$error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
				mismatch_cnt++;
			end
			if (got.green !== want.green) begin
				$error("green_out: expected %0d, actual %0d", want.green, got.green);
				mismatch_cnt++;
			end
			if (got.red !== want.red) begin
				$error("red_out: expected %0d, actual %0d", want.red, got.red);
				mismatch_cnt++;
			end
		endfunction

		function int pending();
			return expected_pix.size();
		endfunction
	endclass

endpackage

### dv/pixel_saturation_adjust_core_tb.sv
// Testbench top for pixel_saturation_adjust_core: directed corner pixels,
// then randomized phases with random idling on both channels and one long
// output hold-off. Depends on psa_pkg, psa_sat_tb_pkg and the block's RTL.
module pixel_saturation_adjust_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psa_pkg::*;
	import psa_sat_tb_pkg::*;

	localparam int PIPE_LATENCY  = 4;
	localparam int DRAIN_MARGIN  = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 200;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_PIXELS  = 138;

	// indexes past the register list; writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_IDX_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IDX_SPARE_HI = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	pix_t                   blue_in;
	pix_t                   green_in;
	pix_t                   red_in;
	logic                   out_valid;
	logic                   out_stall;
	pix_t                   blue_out;
	pix_t                   green_out;
	pix_t                   red_out;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	saturation_checker sat_sb = new();

	bit          idle_on = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned cycle_cnt = 0;

	pixel_saturation_adjust_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs or stalls forever.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL pixel_saturation_adjust_core");
			$finish;
		end
	end

	// Sample both channels at the rising edge. Check the output first so a
	// same-cycle input never lands ahead of an older expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sat_sb.check_pixel({blue_out, green_out, red_out});
			if (in_valid && !in_stall)
				sat_sb.note_pixel({blue_in, green_in, red_in});
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_factor();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return FACTOR_ONE_DEF;
			3:       return 16'd1;
			4:       return 16'($urandom_range(0, 511));
			5:       return 16'($urandom_range(0, 65535));
			6:       return 16'($urandom_range(256, 1023));
			default: return 16'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix3_t rand_pixel();
		pix3_t p;
		pix_t  base;
		case ($urandom_range(0, 9))
			0: begin
				// saturated channels only: 0 or 255
				p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			1: begin
				// near-gray pixel: channels close to the luma
				base    = pix_t'($urandom_range(4, 251));
				p.blue  = base + pix_t'($urandom_range(0, 4)) - 8'd2;
				p.green = base + pix_t'($urandom_range(0, 4)) - 8'd2;
				p.red   = base + pix_t'($urandom_range(0, 4)) - 8'd2;
			end
			default: p = pix3_t'($urandom);
		endcase
		return p;
	endfunction

	// Offer one pixel; hold valid and payload until the block accepts it.
	// Enter and leave at a falling edge.
	task automatic drive_pixel(input pix3_t p);
		int unsigned gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			// drop valid and scramble the idle payload
			in_valid <= 1'b0;
			{blue_in, green_in, red_in} <= 24'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		{blue_in, green_in, red_in} <= p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted pixel has come out.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (sat_sb.pending() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY) @(negedge clk);
	endtask

	// Write one register with the pipeline empty, and mirror it.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain_pixels();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sat_sb.set_reg(idx, data);
	endtask

	// Receiver: random stall runs while idling is on, plus one long
	// hold-off on request, counted here in cycles.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		blue_in   = '0;
		green_in  = '0;
		red_in    = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: factor one, color mode -- pixels pass unchanged.
		drive_pixel({8'd0, 8'd0, 8'd0});
		drive_pixel({8'd255, 8'd255, 8'd255});
		drive_pixel({8'd255, 8'd0, 8'd0});
		drive_pixel({8'd0, 8'd255, 8'd0});
		drive_pixel({8'd0, 8'd0, 8'd255});

		// Zero factor: every channel collapses to the luma.
		write_reg(REG_SATURATION_FACTOR, '0);
		drive_pixel({8'd200, 8'd30, 8'd90});
		drive_pixel({8'd255, 8'd255, 8'd0});

		// Largest factor: blends overshoot and clamp at both ends.
		write_reg(REG_SATURATION_FACTOR, '1);
		drive_pixel({8'd255, 8'd0, 8'd0});
		drive_pixel({8'd0, 8'd255, 8'd255});
		drive_pixel({8'd10, 8'd200, 8'd10});

		// Half factor: sums land exactly halfway and must round up.
		write_reg(REG_SATURATION_FACTOR, 16'd128);
		drive_pixel({8'd1, 8'd0, 8'd0});
		drive_pixel({8'd0, 8'd0, 8'd3});

		// Smallest nonzero factor.
		write_reg(REG_SATURATION_FACTOR, 16'd1);
		drive_pixel({8'd255, 8'd255, 8'd255});

		// Gray-only mode bypasses the blend even with an extreme factor.
		write_reg(REG_SATURATION_FACTOR, '1);
		write_reg(REG_GRAY_ONLY_MODE, 16'd1);
		drive_pixel({8'd255, 8'd0, 8'd255});
		drive_pixel({8'd0, 8'd255, 8'd0});

		// Writes past the register list leave both registers alone.
		write_reg(REG_IDX_SPARE_LO, '0);
		write_reg(REG_IDX_SPARE_HI, '1);
		drive_pixel({8'd17, 8'd34, 8'd51});

		// Random phases: new settings each phase, some phases without idling,
		// one phase under a long output hold-off so the input backs up.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_SATURATION_FACTOR, pick_factor());
			write_reg(REG_GRAY_ONLY_MODE,
				{15'($urandom), 1'($urandom_range(0, 4) == 0)});
			idle_on = (p % 4 != 1);
			if (p == RANDOM_PHASES / 2) begin
				idle_on      = 1'b0;
				hold_off_req = 1'b1;
			end
			repeat (PHASE_PIXELS) drive_pixel(rand_pixel());
		end

		drain_pixels();
		repeat (DRAIN_MARGIN) @(negedge clk);
		if (sat_sb.mismatch_cnt == 0 && sat_sb.pending() == 0)
			$display("PASS pixel_saturation_adjust_core");
		else
			$display("FAIL pixel_saturation_adjust_core");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/psa_pkg.sv
rtl/psa_luma.sv
rtl/psa_blend.sv
rtl/psa_skid.sv
rtl/pixel_saturation_adjust_core.sv
dv/psa_sat_tb_pkg.sv
dv/pixel_saturation_adjust_core_tb.sv
